FILE: design/timestamped_aging_fifo_assert.svh
// Assertion macros used by the timestamped aging FIFO top level.
`ifndef TIMESTAMPED_AGING_FIFO_ASSERT_SVH
`define TIMESTAMPED_AGING_FIFO_ASSERT_SVH

// same-cycle implication
`define TAF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/taf_pkg.sv
// Types, codes and constants of the timestamped aging FIFO.
package taf_pkg;

  localparam int DEPTH = 16;
  localparam logic [31:0] LIFETIME_RST = 32'd1000;
  localparam int CFG_AW = 3;
  localparam logic REG_LIFETIME = 1'b0;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_INSERT = 3'd1;
  localparam logic [2:0] FUNC_LIST   = 3'd2;
  localparam logic [2:0] FUNC_CHECK  = 3'd3;
  localparam logic [2:0] FUNC_LATER  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] data;
    logic [31:0]        query_time;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_data;
    logic [31:0]        entry_time;
    logic               all_later;
    logic [4:0]         occupancy;
    logic               last;
  } out_t;

  typedef enum logic {
    CMP_AGED,
    CMP_LATER
  } cmp_op_t;

  typedef struct packed {
    cmp_op_t     op;
    logic [31:0] ref_time;
    logic [31:0] stamp;
    logic [31:0] limit;
  } cmp_req_t;

endpackage

FILE: design/taf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module taf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/taf_cmp.sv
// Shared stamp compare unit: age against lifetime, or stamp against query time.
module taf_cmp (
  input  taf_pkg::cmp_req_t req,
  output logic              hit
);

  logic [31:0] age;

  assign age = req.ref_time - req.stamp;

  always_comb begin
    case (req.op)
      taf_pkg::CMP_AGED:  hit = (age >= req.limit);
      taf_pkg::CMP_LATER: hit = (req.stamp > req.ref_time);
      default:            hit = 1'b0;
    endcase
  end

endmodule

FILE: design/taf_regs.sv
// APB register file holding the entry lifetime.
module taf_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [taf_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [31:0]                lifetime
);

  logic [31:0] lifetime_r;
  logic        wr_en;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready
                    && (paddr[2] == taf_pkg::REG_LIFETIME);
  assign prdata   = (paddr[2] == taf_pkg::REG_LIFETIME) ? lifetime_r : 32'd0;
  assign lifetime = lifetime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= taf_pkg::LIFETIME_RST;
    end else if (wr_en) begin
      lifetime_r <= pwdata;
    end
  end

endmodule

FILE: design/timestamped_aging_fifo.sv
// Top level: sequencer, entry RAM and shared compare unit of the aging FIFO.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  input    | start, busy, in_item                    | start && !busy
//  result   | out_valid, out_item                     | out_valid, one cycle
//  config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// Sequence per command: insert and unused codes are answered from S_IDLE and busy
// stays low; tick expires aged head entries through S_EXP_RD and S_EXP_CMP, then
// returns; list live and list later run the same expiry scan, then walk the live
// entries in S_WALK; the all-later check walks the entries without expiring any.
// Synchronous active-low reset clears control state; the RAM is not cleared.
// Results are strobed for one cycle and cannot be stalled.
`include "timestamped_aging_fifo_assert.svh"

module timestamped_aging_fifo #(
  parameter int DEPTH = taf_pkg::DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  taf_pkg::in_t               in_item,
  output logic                       out_valid,
  output taf_pkg::out_t              out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [taf_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [AW:0] DEPTH_AX = (AW + 1)'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXP_RD,
    S_EXP_CMP,
    S_WALK
  } state_t;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] k);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW + 1)'(k);
    if (sum >= DEPTH_AX) begin
      sum = sum - DEPTH_AX;
    end
    return sum[AW-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [2:0]        func_r, func_nxt;
  logic [31:0]       qt_r, qt_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [31:0]       pend_word_r, pend_word_nxt;
  logic [31:0]       pend_time_r, pend_time_nxt;
  logic              all_r, all_nxt;
  logic              out_valid_r, out_valid_nxt;
  taf_pkg::out_t     out_r, out_nxt;

  logic [31:0]       lifetime;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [63:0]       rdata;
  taf_pkg::cmp_req_t cmp_req;
  logic              cmp_hit;
  logic              accept;
  logic              ins_acc;
  logic              match;
  logic              more;

  taf_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .lifetime (lifetime)
  );

  taf_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({now_r, in_item.data}),
    .raddr (raddr),
    .rdata (rdata)
  );

  taf_cmp u_cmp (
    .req (cmp_req),
    .hit (cmp_hit)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign ins_acc   = accept && (in_item.func == taf_pkg::FUNC_INSERT);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign more      = (k_r < count_r);
  assign waddr     = slot(head_r, count_r);
  assign we        = ins_acc && (count_r < DEPTH_CW);
  assign raddr     = (state_r == S_WALK) ? slot(head_r, k_r) : head_r;

  always_comb begin
    cmp_req.op       = (state_r == S_EXP_CMP) ? taf_pkg::CMP_AGED : taf_pkg::CMP_LATER;
    cmp_req.ref_time = (state_r == S_EXP_CMP) ? now_r : qt_r;
    cmp_req.stamp    = rdata[63:32];
    cmp_req.limit    = lifetime;
  end

  always_comb begin
    case (func_r)
      taf_pkg::FUNC_LIST:  match = 1'b1;
      taf_pkg::FUNC_LATER: match = cmp_hit;
      default:             match = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    qt_nxt        = qt_r;
    now_nxt       = now_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    rd_v_nxt      = rd_v_r;
    pend_v_nxt    = pend_v_r;
    pend_word_nxt = pend_word_r;
    pend_time_nxt = pend_time_r;
    all_nxt       = all_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    out_nxt.status     = taf_pkg::ST_OK;
    out_nxt.entry_data = '0;
    out_nxt.entry_time = '0;
    out_nxt.all_later  = 1'b0;
    out_nxt.occupancy  = 5'(count_r);
    out_nxt.last       = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt = in_item.func;
          qt_nxt   = in_item.query_time;
          k_nxt    = '0;
          rd_v_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          all_nxt  = 1'b1;
          case (in_item.func)
            taf_pkg::FUNC_TICK: begin
              now_nxt   = (now_r == '1) ? now_r : now_r + 32'd1;
              state_nxt = S_EXP_RD;
            end
            taf_pkg::FUNC_INSERT: begin
              out_valid_nxt = 1'b1;
              if (count_r >= DEPTH_CW) begin
                out_nxt.status = taf_pkg::ST_FULL;
              end else begin
                count_nxt         = count_r + CW'(1);
                out_nxt.occupancy = 5'(count_r + CW'(1));
              end
            end
            taf_pkg::FUNC_LIST, taf_pkg::FUNC_LATER: begin
              state_nxt = S_EXP_RD;
            end
            taf_pkg::FUNC_CHECK: begin
              state_nxt = S_WALK;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_EXP_RD: begin
        if (count_r != '0) begin
          state_nxt = S_EXP_CMP;
        end else if (func_r == taf_pkg::FUNC_TICK) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_EXP_CMP: begin
        if (cmp_hit) begin
          head_nxt  = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
          count_nxt = count_r - CW'(1);
          state_nxt = S_EXP_RD;
        end else if (func_r == taf_pkg::FUNC_TICK) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        rd_v_nxt = more;
        if (more) begin
          k_nxt = k_r + CW'(1);
        end
        if (rd_v_r) begin
          if (func_r == taf_pkg::FUNC_CHECK && !cmp_hit) begin
            all_nxt = 1'b0;
          end
          if (match) begin
            if (pend_v_r) begin
              out_valid_nxt      = 1'b1;
              out_nxt.entry_data = pend_word_r;
              out_nxt.entry_time = pend_time_r;
              out_nxt.last       = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_word_nxt = rdata[31:0];
            pend_time_nxt = rdata[63:32];
          end
        end else if (!more) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (func_r == taf_pkg::FUNC_CHECK) begin
            out_nxt.all_later = all_r;
          end else if (pend_v_r) begin
            out_nxt.entry_data = pend_word_r;
            out_nxt.entry_time = pend_time_r;
          end else begin
            out_nxt.status = taf_pkg::ST_EMPTY;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      func_r      <= taf_pkg::FUNC_TICK;
      now_r       <= '0;
      head_r      <= '0;
      count_r     <= '0;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      all_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      now_r       <= now_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      rd_v_r      <= rd_v_nxt;
      pend_v_r    <= pend_v_nxt;
      all_r       <= all_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qt_r        <= qt_nxt;
    pend_word_r <= pend_word_nxt;
    pend_time_r <= pend_time_nxt;
    out_r       <= out_nxt;
  end

  `TAF_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, count_r <= DEPTH_CW, "count above depth")
  `TAF_ASSERT_IMP(a_last_idle, clk, rst_n, out_valid && out_item.last, !busy, "busy after last")
  `TAF_ASSERT_NXT(a_ins_done, clk, rst_n, ins_acc, out_valid && out_item.last, "insert no beat")
  `TAF_ASSERT_NXT(a_time_mono, clk, rst_n, 1'b1, now_r >= $past(now_r), "time went back")
  `TAF_ASSERT_IMP(a_walk_idx, clk, rst_n, state_r == S_WALK, k_r <= count_r, "walk overrun")

endmodule
